FILE: src/pft_pkg.sv
// shared types and constants for the particle fate tally
package pft_pkg;

   // function codes of an input item
   localparam logic [1:0] FUNC_EVENT = 2'd0;
   localparam logic [1:0] FUNC_FLUSH = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // fate categories, secondaries sit three above primaries
   localparam logic [2:0] CAT_UP         = 3'd0;
   localparam logic [2:0] CAT_DOWN       = 3'd1;
   localparam logic [2:0] CAT_ABSORBED   = 3'd2;
   localparam logic [2:0] CAT_SECONDARY  = 3'd3;
   localparam int         NUM_CATS       = 6;

   localparam int NUM_TYPES_DEFAULT = 8;

   localparam int PEND_W = 40;
   localparam int SUM_W  = 64;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         particle_type;
      logic [7:0]         generation_label;
      logic [7:0]         material_index;
      logic signed [15:0] direction_z;
      logic [31:0]        weight;
      logic [2:0]         category;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]  weight_sum;
      logic [SUM_W-1:0]  weight_square_sum;
      logic [PEND_W-1:0] pending_weight;
   } rsp_type;

   // one word of the tally memory
   typedef struct packed {
      logic [PEND_W-1:0] pending_weight;
      logic [SUM_W-1:0]  weight_sum;
      logic [SUM_W-1:0]  weight_square_sum;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: src/pft_ram.sv
// generic simple dual-port ram with registered read
module pft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/particle_fate_tally.sv
// particle fate tally: per-history accumulators with running sums and sums of squares
//
//   port group   dir   payload              transfer when
//   req_*        in    pft_pkg::req_type    req_valid && !req_stall
//   rsp_*        out   pft_pkg::rsp_type    rsp_valid && !rsp_stall
//
// an event reads its entry, then writes the sum back
// a read waits in ST_READ while the previous result still sits in rsp
// a flush walks all 6*NUM_TYPES entries through a 3-stage squaring pipeline;
//   the single memory read port sets the pace
// after reset a clearing pass zeroes the memory, req stalled
// rsp_stall holds a finished read result and a further read, which stalls req; events and flushes flow until then
module particle_fate_tally #(
   parameter int NUM_TYPES = pft_pkg::NUM_TYPES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pft_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pft_pkg::rsp_type rsp_data
);

   localparam int ENTRIES = pft_pkg::NUM_CATS * NUM_TYPES;
   localparam int AW      = $clog2(ENTRIES);
   localparam int IW      = AW + 3;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRIES - 1);
   localparam logic [6:0]    TYPES_W    = 7'(NUM_TYPES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVENT,
      ST_READ,
      ST_FLUSH
   } state_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   state_type state_ff, state_in;

   // shared counter: clearing pass address, flush issue address
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          issue_ff, issue_in;

   logic [AW-1:0] ev_addr_ff, ev_addr_in;
   logic [31:0]   ev_weight_ff, ev_weight_in;
   logic          rd_zero_ff, rd_zero_in;

   logic             rsp_valid_ff, rsp_valid_in;
   pft_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // memory ports
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   pft_pkg::entry_type mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   pft_pkg::entry_type mem_rd_data;

   // flush pipeline: d1 = ram output, s2 = products, s3 = partial sums
   logic          d1_vld_ff;
   logic [AW-1:0] d1_addr_ff;
   logic          s2_vld_ff;
   logic [AW-1:0] s2_addr_ff;
   logic          s2_nz_ff;
   logic [39:0]   s2_acc_ff;
   logic [63:0]   s2_sum_ff;
   logic [63:0]   s2_sqsum_ff;
   logic [39:0]   s2_hh_ff;
   logic [39:0]   s2_hl_ff;
   logic [39:0]   s2_ll_ff;
   logic          s3_vld_ff;
   logic [AW-1:0] s3_addr_ff;
   logic          s3_nz_ff;
   logic [63:0]   s3_sum_ff;
   logic [63:0]   s3_sqsum_ff;
   logic [63:0]   s3_sqadd_ff;

   // request decode
   logic          req_accept;
   logic          type_ok;
   logic [2:0]    fate;
   logic [2:0]    cat_sel;
   logic [IW-1:0] idx_wide;
   logic [AW-1:0] idx;
   logic          event_ok;
   logic          read_ok;
   logic [40:0]   acc_add;
   logic [39:0]   acc_new;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign type_ok = ({4'd0, req_data.particle_type} < TYPES_W);

   // escaped upward only for a strictly positive z cosine
   always_comb begin
      if (req_data.material_index != 8'd0) begin
         fate = pft_pkg::CAT_ABSORBED;
      end else if (req_data.direction_z > 16'sd0) begin
         fate = pft_pkg::CAT_UP;
      end else begin
         fate = pft_pkg::CAT_DOWN;
      end
      if (req_data.generation_label > 8'd1) begin
         fate = fate + pft_pkg::CAT_SECONDARY;
      end
   end

   assign cat_sel  = (req_data.func == pft_pkg::FUNC_READ) ? req_data.category : fate;
   assign idx_wide = IW'(cat_sel) * IW'(NUM_TYPES) + IW'(req_data.particle_type);
   assign idx      = idx_wide[AW-1:0];

   assign event_ok = (req_data.func == pft_pkg::FUNC_EVENT) && type_ok;
   assign read_ok  = type_ok && (req_data.category < 3'(pft_pkg::NUM_CATS));

   // saturating accumulator update for an event
   assign acc_add = {1'b0, mem_rd_data.pending_weight} + {9'd0, ev_weight_ff};
   assign acc_new = acc_add[40] ? '1 : acc_add[39:0];

   // memory read port
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx;
      case (state_ff)
         ST_IDLE: begin
            mem_rd_en = req_accept && (event_ok ||
                        ((req_data.func == pft_pkg::FUNC_READ) && read_ok));
         end
         ST_FLUSH: begin
            mem_rd_en   = issue_ff;
            mem_rd_addr = cnt_ff;
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // memory write port
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cnt_ff;
      mem_wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_EVENT: begin
            mem_wr_en                     = 1'b1;
            mem_wr_addr                   = ev_addr_ff;
            mem_wr_data                   = mem_rd_data;
            mem_wr_data.pending_weight    = acc_new;
         end
         ST_FLUSH: begin
            // fold the history total in and clear the accumulator
            mem_wr_en                     = s3_vld_ff && s3_nz_ff;
            mem_wr_addr                   = s3_addr_ff;
            mem_wr_data.pending_weight    = '0;
            mem_wr_data.weight_sum        = s3_sum_ff;
            mem_wr_data.weight_square_sum = sat_add64(s3_sqsum_ff, s3_sqadd_ff);
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   pft_ram #(
      .WIDTH (pft_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_tally_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // control next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      ev_addr_in   = ev_addr_ff;
      ev_weight_in = ev_weight_ff;
      rd_zero_in   = rd_zero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == LAST_ENTRY) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.func)
                  pft_pkg::FUNC_EVENT: begin
                     ev_addr_in   = idx;
                     ev_weight_in = req_data.weight;
                     if (type_ok) begin
                        state_in = ST_EVENT;
                     end
                  end
                  pft_pkg::FUNC_FLUSH: begin
                     cnt_in   = '0;
                     issue_in = 1'b1;
                     state_in = ST_FLUSH;
                  end
                  pft_pkg::FUNC_READ: begin
                     rd_zero_in = !read_ok;
                     state_in   = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EVENT: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (rd_zero_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in.weight_sum        = mem_rd_data.weight_sum;
                  rsp_data_in.weight_square_sum = mem_rd_data.weight_square_sum;
                  rsp_data_in.pending_weight    = mem_rd_data.pending_weight;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (issue_ff) begin
               if (cnt_ff == LAST_ENTRY) begin
                  issue_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end else if (!d1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ev_addr_ff   <= ev_addr_in;
      ev_weight_ff <= ev_weight_in;
      rd_zero_ff   <= rd_zero_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // flush pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff <= (state_ff == ST_FLUSH) && issue_ff;
         s2_vld_ff <= d1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // flush pipeline data: split the 40-bit accumulator into 20-bit halves for partial products
   always_ff @(posedge clock) begin
      d1_addr_ff  <= cnt_ff;

      s2_addr_ff  <= d1_addr_ff;
      s2_nz_ff    <= (mem_rd_data.pending_weight != '0);
      s2_acc_ff   <= mem_rd_data.pending_weight;
      s2_sum_ff   <= mem_rd_data.weight_sum;
      s2_sqsum_ff <= mem_rd_data.weight_square_sum;
      s2_hh_ff    <= mem_rd_data.pending_weight[39:20] * mem_rd_data.pending_weight[39:20];
      s2_hl_ff    <= mem_rd_data.pending_weight[39:20] * mem_rd_data.pending_weight[19:0];
      s2_ll_ff    <= mem_rd_data.pending_weight[19:0] * mem_rd_data.pending_weight[19:0];

      // floor(acc^2 / 2^16), exact: the only fractional part is in lo*lo
      s3_addr_ff  <= s2_addr_ff;
      s3_nz_ff    <= s2_nz_ff;
      s3_sum_ff   <= sat_add64(s2_sum_ff, {24'd0, s2_acc_ff});
      s3_sqsum_ff <= s2_sqsum_ff;
      s3_sqadd_ff <= {s2_hh_ff, 24'd0} + {19'd0, s2_hl_ff, 5'd0}
                     + {40'd0, s2_ll_ff[39:16]};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // the clearing pass keeps the request side closed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");

   // a new result only ever comes out of a read
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("result raised without a read");

   // no memory write while the block sits idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("memory written while idle");

   // an in-range event goes straight to its write-back
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && event_ok) |=> (state_ff == ST_EVENT))
      else $error("event did not reach write-back");

   // flush pipeline only runs inside a flush
   assert property (@(posedge clock) disable iff (reset)
      (d1_vld_ff || s2_vld_ff || s3_vld_ff) |-> (state_ff == ST_FLUSH))
      else $error("flush pipeline active outside flush");
`endif

endmodule
